>>> sv/sct_pkg.sv
// sct_pkg: shared types, codes and helper functions of the script tokenizer
// result record, result pair, mode and event codes, token kinds, keyword words
// no dependencies
`timescale 1ns / 1ps

package sct_pkg;

	localparam int unsigned POS_W   = 16;
	localparam int unsigned NUM_W   = 31;
	localparam int unsigned FIFO_AW = 2;
	localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	typedef enum logic [6:0] {
		M_IDLE  = 7'b0000001,
		M_NUM   = 7'b0000010,
		M_ZERO  = 7'b0000100,
		M_WORD  = 7'b0001000,
		M_NAME  = 7'b0010000,
		M_QUOTE = 7'b0100000,
		M_SKIP  = 7'b1000000
	} mode_t;

	localparam logic [2:0] EV_TEXT     = 3'd0;
	localparam logic [2:0] EV_DONE     = 3'd1;
	localparam logic [2:0] EV_ERR      = 3'd2;
	localparam logic [2:0] EV_END_OK   = 3'd3;
	localparam logic [2:0] EV_END_FAIL = 3'd4;

	localparam logic [4:0] K_SEP    = 5'd0;
	localparam logic [4:0] K_ADD    = 5'd1;
	localparam logic [4:0] K_SUB    = 5'd2;
	localparam logic [4:0] K_EQ     = 5'd3;
	localparam logic [4:0] K_NOT    = 5'd4;
	localparam logic [4:0] K_MARK   = 5'd5;
	localparam logic [4:0] K_RIGHT  = 5'd8;
	localparam logic [4:0] K_LEFT   = 5'd9;
	localparam logic [4:0] K_NUM    = 5'd10;
	localparam logic [4:0] K_QUOTE  = 5'd11;
	localparam logic [4:0] K_LPAR   = 5'd12;
	localparam logic [4:0] K_RPAR   = 5'd13;
	localparam logic [4:0] K_WORD   = 5'd14;
	localparam logic [4:0] K_TO     = 5'd15;
	localparam logic [4:0] K_IF     = 5'd16;
	localparam logic [4:0] K_ELIF   = 5'd17;
	localparam logic [4:0] K_ELSE   = 5'd18;
	localparam logic [4:0] K_THEN   = 5'd19;
	localparam logic [4:0] K_END    = 5'd20;
	localparam logic [4:0] K_EOF    = 5'd21;

	localparam logic [0:0] ERR_LEAD_ZERO = 1'b0;
	localparam logic [0:0] ERR_OPEN_QUOTE = 1'b1;

	// keyword words, first byte in the low byte
	localparam logic [31:0] KW_TO   = 32'h0000_6F74;
	localparam logic [31:0] KW_IF   = 32'h0000_6669;
	localparam logic [31:0] KW_ELIF = 32'h6669_6C65;
	localparam logic [31:0] KW_ELSE = 32'h6573_6C65;
	localparam logic [31:0] KW_THEN = 32'h6E65_6874;
	localparam logic [31:0] KW_END  = 32'h0064_6E65;

	localparam logic [7:0] CH_EOT   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h27;

	typedef struct packed {
		logic [2:0]       event_res;
		logic [4:0]       kind;
		logic [7:0]       text_byte;
		logic [NUM_W-1:0] number_value;
		logic             error_code;
		logic [POS_W-1:0] line;
		logic [POS_W-1:0] column;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} res_push_t;

	function automatic result_t make_res(input logic [2:0] ev, input logic [4:0] kind,
			input logic [7:0] text, input logic [NUM_W-1:0] num, input logic err,
			input logic [POS_W-1:0] ln, input logic [POS_W-1:0] col);
		result_t r;
		r.event_res    = ev;
		r.kind         = kind;
		r.text_byte    = text;
		r.number_value = num;
		r.error_code   = err;
		r.line         = ln;
		r.column       = col;
		r.last         = 1'b0;
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_") ||
			(c == 8'hA8) || (c == 8'hB8) || (c >= 8'hC0);
	endfunction

	function automatic logic [4:0] word_kind(input logic [31:0] b, input logic [2:0] len);
		logic [4:0] k;
		k = K_WORD;
		if (len == 3'd2 && b == KW_TO) k = K_TO;
		else if (len == 3'd2 && b == KW_IF) k = K_IF;
		else if (len == 3'd4 && b == KW_ELIF) k = K_ELIF;
		else if (len == 3'd4 && b == KW_ELSE) k = K_ELSE;
		else if (len == 3'd4 && b == KW_THEN) k = K_THEN;
		else if (len == 3'd3 && b == KW_END) k = K_END;
		return k;
	endfunction

endpackage

>>> sv/script_char_tokenizer_core.sv
// script_char_tokenizer_core: top level, input byte register, lexer and result queue
// depends on sct_pkg, sct_lexer, sct_res_fifo
//
// usage:
//   input channel ch / ch_valid / ch_ready carries one cp1251 byte per transfer;
//   a zero byte ends the text and the tokenizer restarts for the next text
//   result channel res_valid / res_ready carries one result per transfer with
//   event_res, kind, text_byte, number_value, error_code, line, column, last;
//   last marks the final result caused by one input byte
//   a byte is registered in the input register, decoded by the lexer and its
//   results are written into the result queue, which then offers the first one
//   throughput: one byte per cycle while the result queue has room; a byte that
//   gives two results puts both into the four-entry result queue at once
//   bytes that give no result (digits, spaces, skipped input) still wait for room
//   the lexer stalls while the queue has fewer than two free entries, so a
//   stalled receiver backs up into ch_ready once the queue holds more than two results
//   reset: arst_n clears position to line 1 column 0, mode to idle, and
//   empties the input register and the result queue
`timescale 1ns / 1ps

module script_char_tokenizer_core import sct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ch_valid,
	output logic             ch_ready,
	input  logic [7:0]       ch,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [2:0]       event_res,
	output logic [4:0]       kind,
	output logic [7:0]       text_byte,
	output logic [NUM_W-1:0] number_value,
	output logic             error_code,
	output logic [POS_W-1:0] line,
	output logic [POS_W-1:0] column,
	output logic             last
);

	logic      valid_s1;
	logic [7:0] ch_s1;
	logic      item_fire, space_ok;
	res_push_t push;
	result_t   out_res;

	assign ch_ready = ~valid_s1 | item_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ch_ready) begin
			valid_s1 <= ch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_ready && ch_valid) begin
			ch_s1 <= ch;
		end
	end

	sct_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_ch    (ch_s1),
		.space_ok   (space_ok),
		.item_fire  (item_fire),
		.push       (push)
	);

	sct_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (item_fire),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_res   (out_res)
	);

	assign event_res    = out_res.event_res;
	assign kind         = out_res.kind;
	assign text_byte    = out_res.text_byte;
	assign number_value = out_res.number_value;
	assign error_code   = out_res.error_code;
	assign line         = out_res.line;
	assign column       = out_res.column;
	assign last         = out_res.last;

endmodule

>>> sv/sct_lexer.sv
// sct_lexer: tokenizer state and per-byte decode, up to two results per byte
// depends on sct_pkg
`timescale 1ns / 1ps

module sct_lexer import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic [7:0] item_ch,
	input  logic      space_ok,
	output logic      item_fire,
	output res_push_t push
);

	mode_t            mode_q, mode_d;
	logic [1:0]       name_kind_q, name_kind_d;
	logic [POS_W-1:0] cur_line_q, cur_line_d;
	logic [POS_W-1:0] cur_column_q, cur_column_d;
	logic [POS_W-1:0] start_line_q, start_line_d;
	logic [POS_W-1:0] start_column_q, start_column_d;
	logic [NUM_W-1:0] num_accum_q, num_accum_d;
	logic [31:0]      word_bytes_q, word_bytes_d;
	logic [2:0]       word_len_q, word_len_d;
	logic             failed_q, failed_d;

	logic [POS_W-1:0] col;
	logic [NUM_W+3:0] num_next;
	logic [7:0]       c;
	logic             pre_v, dsp_v, again, do_reset, op_hit;
	logic [4:0]       op_kind;
	result_t          pre, dsp;

	assign c = item_ch;
	assign item_fire = item_valid & space_ok;
	assign col = cur_column_q + 1'b1;
	assign num_next = {1'b0, num_accum_q, 3'b000} + {3'b000, num_accum_q, 1'b0} +
		{{NUM_W{1'b0}}, c[3:0]};

	always_comb begin
		op_hit  = 1'b1;
		op_kind = K_SEP;
		case (c)
			";": op_kind = K_SEP;
			"+": op_kind = K_ADD;
			"-": op_kind = K_SUB;
			"=": op_kind = K_EQ;
			"!": op_kind = K_NOT;
			">": op_kind = K_RIGHT;
			"<": op_kind = K_LEFT;
			"(": op_kind = K_LPAR;
			")": op_kind = K_RPAR;
			default: op_hit = 1'b0;
		endcase
	end

	always_comb begin
		mode_d         = mode_q;
		name_kind_d    = name_kind_q;
		cur_line_d     = cur_line_q;
		cur_column_d   = col;
		start_line_d   = start_line_q;
		start_column_d = start_column_q;
		num_accum_d    = num_accum_q;
		word_bytes_d   = word_bytes_q;
		word_len_d     = word_len_q;
		failed_d       = failed_q;
		pre_v    = 1'b0;
		dsp_v    = 1'b0;
		pre      = '0;
		dsp      = '0;
		again    = 1'b0;
		do_reset = 1'b0;

		case (mode_q)
			M_SKIP: begin
				if (c == CH_EOT) begin
					dsp_v = 1'b1;
					dsp = make_res(EV_END_FAIL, K_EOF, 8'd0, '0, 1'b0, cur_line_q, col);
					do_reset = 1'b1;
				end
			end
			M_QUOTE: begin
				pre_v = 1'b1;
				if (c == CH_QUOTE) begin
					pre = make_res(EV_DONE, K_QUOTE, 8'd0, '0, 1'b0,
						start_line_q, start_column_q);
					mode_d = M_IDLE;
				end else if (c == CH_EOT) begin
					pre = make_res(EV_ERR, K_SEP, 8'd0, '0, ERR_OPEN_QUOTE, cur_line_q, col);
					dsp_v = 1'b1;
					dsp = make_res(EV_END_FAIL, K_EOF, 8'd0, '0, 1'b0, cur_line_q, col);
					do_reset = 1'b1;
				end else begin
					pre = make_res(EV_TEXT, K_QUOTE, c, '0, 1'b0,
						start_line_q, start_column_q);
				end
			end
			M_NUM: begin
				if (is_digit(c)) begin
					num_accum_d = (num_next[NUM_W+3:NUM_W] != 4'd0) ? NUM_MAX :
						num_next[NUM_W-1:0];
				end else begin
					pre_v = 1'b1;
					pre = make_res(EV_DONE, K_NUM, 8'd0, num_accum_q, 1'b0,
						start_line_q, start_column_q);
					mode_d = M_IDLE;
					again = 1'b1;
				end
			end
			M_ZERO: begin
				pre_v = 1'b1;
				if (is_digit(c)) begin
					pre = make_res(EV_ERR, K_SEP, 8'd0, '0, ERR_LEAD_ZERO, cur_line_q, col);
					failed_d = 1'b1;
					mode_d = M_SKIP;
				end else begin
					pre = make_res(EV_DONE, K_NUM, 8'd0, '0, 1'b0,
						start_line_q, start_column_q);
					mode_d = M_IDLE;
					again = 1'b1;
				end
			end
			M_WORD: begin
				pre_v = 1'b1;
				if (c != CH_SP && c != ";" && c != CH_NL && c != CH_EOT) begin
					if (word_len_q < 3'd4) begin
						word_bytes_d[8*word_len_q[1:0] +: 8] = c;
					end
					if (word_len_q < 3'd5) begin
						word_len_d = word_len_q + 3'd1;
					end
					pre = make_res(EV_TEXT, K_WORD, c, '0, 1'b0,
						start_line_q, start_column_q);
				end else begin
					pre = make_res(EV_DONE, word_kind(word_bytes_q, word_len_q), 8'd0, '0,
						1'b0, start_line_q, start_column_q);
					mode_d = M_IDLE;
					again = 1'b1;
				end
			end
			M_NAME: begin
				pre_v = 1'b1;
				if (is_alpha(c) || is_digit(c)) begin
					pre = make_res(EV_TEXT, K_MARK + {3'b000, name_kind_q}, c, '0, 1'b0,
						start_line_q, start_column_q);
				end else begin
					pre = make_res(EV_DONE, K_MARK + {3'b000, name_kind_q}, 8'd0, '0, 1'b0,
						start_line_q, start_column_q);
					mode_d = M_IDLE;
					again = 1'b1;
				end
			end
			default: begin
				mode_d = M_IDLE;
				again = 1'b1;
			end
		endcase

		if (again) begin
			if (op_hit) begin
				dsp_v = 1'b1;
				dsp = make_res(EV_DONE, op_kind, 8'd0, '0, 1'b0, cur_line_q, col);
			end else if (c == CH_SP || c == CH_NL) begin
				dsp_v = 1'b0;
			end else if (c == CH_EOT) begin
				dsp_v = 1'b1;
				dsp = make_res(failed_q ? EV_END_FAIL : EV_END_OK, K_EOF, 8'd0, '0, 1'b0,
					cur_line_q, col);
				do_reset = 1'b1;
			end else begin
				start_line_d = cur_line_q;
				start_column_d = col;
				dsp_v = 1'b1;
				if (c == ":" || c == "@" || c == "$") begin
					name_kind_d = (c == ":") ? 2'd0 : (c == "@") ? 2'd1 : 2'd2;
					mode_d = M_NAME;
					dsp = make_res(EV_TEXT, K_MARK + {3'b000, name_kind_d}, c, '0, 1'b0,
						cur_line_q, col);
				end else if (c == "0") begin
					dsp_v = 1'b0;
					mode_d = M_ZERO;
				end else if (is_digit(c)) begin
					dsp_v = 1'b0;
					num_accum_d = {{(NUM_W - 4){1'b0}}, c[3:0]};
					mode_d = M_NUM;
				end else if (c == CH_QUOTE) begin
					mode_d = M_QUOTE;
					dsp = make_res(EV_TEXT, K_QUOTE, c, '0, 1'b0, cur_line_q, col);
				end else begin
					word_bytes_d = {24'd0, c};
					word_len_d = 3'd1;
					mode_d = M_WORD;
					dsp = make_res(EV_TEXT, K_WORD, c, '0, 1'b0, cur_line_q, col);
				end
			end
		end

		if (do_reset) begin
			mode_d         = M_IDLE;
			name_kind_d    = 2'd0;
			cur_line_d     = POS_W'(1);
			cur_column_d   = '0;
			start_line_d   = POS_W'(1);
			start_column_d = '0;
			num_accum_d    = '0;
			word_bytes_d   = '0;
			word_len_d     = 3'd0;
			failed_d       = 1'b0;
		end else if (c == CH_NL) begin
			cur_line_d = cur_line_q + 1'b1;
			cur_column_d = '0;
		end
	end

	// pack the first and second result, flag the final one
	always_comb begin
		push = '0;
		if (pre_v) begin
			push.r0 = pre;
			push.r1 = dsp;
			push.n = dsp_v ? 2'd2 : 2'd1;
			push.r0.last = ~dsp_v;
			push.r1.last = dsp_v;
		end else begin
			push.r0 = dsp;
			push.n = dsp_v ? 2'd1 : 2'd0;
			push.r0.last = dsp_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= M_IDLE;
			name_kind_q    <= 2'd0;
			cur_line_q     <= POS_W'(1);
			cur_column_q   <= '0;
			start_line_q   <= POS_W'(1);
			start_column_q <= '0;
			num_accum_q    <= '0;
			word_bytes_q   <= '0;
			word_len_q     <= 3'd0;
			failed_q       <= 1'b0;
		end else if (item_fire) begin
			mode_q         <= mode_d;
			name_kind_q    <= name_kind_d;
			cur_line_q     <= cur_line_d;
			cur_column_q   <= cur_column_d;
			start_line_q   <= start_line_d;
			start_column_q <= start_column_d;
			num_accum_q    <= num_accum_d;
			word_bytes_q   <= word_bytes_d;
			word_len_q     <= word_len_d;
			failed_q       <= failed_d;
		end
	end

endmodule

>>> sv/sct_res_fifo.sv
// sct_res_fifo: small result queue, takes up to two results per cycle, gives one
// depends on sct_pkg
`timescale 1ns / 1ps

module sct_res_fifo import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_en,
	input  res_push_t push,
	output logic      space_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   out_res
);

	result_t            mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [FIFO_AW:0]   count_q;
	logic [1:0]         n_in;
	logic               pop;

	assign n_in = push_en ? push.n : 2'd0;
	assign pop = out_valid & out_ready;
	assign out_valid = (count_q != '0);
	assign out_res = mem[rd_ptr_q];
	assign space_ok = (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (n_in == 2'd2) begin
			mem[wr_ptr_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_in);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW + 1)'(n_in) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

>>> sim/script_char_tokenizer_core_tb.sv
// script_char_tokenizer_core_tb: self-checking testbench of the script tokenizer core
// a clocked driver and monitor, an in-bench lexer that predicts every result, directed and
// random texts under three idle patterns; depends on sct_pkg and script_char_tokenizer_core
`timescale 1ns / 1ps

module script_char_tokenizer_core_tb;
	import sct_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             ch_valid = 1'b0;
	logic             ch_ready;
	logic [7:0]       ch = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	logic [2:0]       event_res;
	logic [4:0]       kind;
	logic [7:0]       text_byte;
	logic [NUM_W-1:0] number_value;
	logic             error_code;
	logic [POS_W-1:0] line;
	logic [POS_W-1:0] column;
	logic             last;

	logic [7:0] src_bytes [$];
	result_t    token_events_due [$];

	int send_idle = 0;
	int recv_idle = 0;
	int failures = 0;
	int bytes_built = 0;
	int texts_built = 0;
	int bytes_sent = 0;
	int results_seen = 0;

	string single_ops = ";+-=!><()";
	string name_marks = ":@$";

	// lexer state mirrored by the bench
	mode_t            lex_state;
	logic [1:0]       prefix_kind;
	logic [POS_W-1:0] pos_line;
	logic [POS_W-1:0] pos_col;
	logic [POS_W-1:0] tok_line;
	logic [POS_W-1:0] tok_col;
	logic [NUM_W-1:0] num_val;
	logic [31:0]      kw_buf;
	logic [2:0]       kw_len;
	logic             text_failed;

	script_char_tokenizer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch_valid     (ch_valid),
		.ch_ready     (ch_ready),
		.ch           (ch),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.event_res    (event_res),
		.kind         (kind),
		.text_byte    (text_byte),
		.number_value (number_value),
		.error_code   (error_code),
		.line         (line),
		.column       (column),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic logic dec_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic name_tail(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" ||
			c == 8'hA8 || c == 8'hB8 || c >= 8'hC0 || dec_digit(c);
	endfunction

	function automatic result_t token_event(input logic [2:0] ev, input logic [4:0] k,
			input logic [7:0] tb, input logic [NUM_W-1:0] val, input logic ec,
			input logic [POS_W-1:0] ln, input logic [POS_W-1:0] col);
		return {ev, k, tb, val, ec, ln, col, 1'b0};
	endfunction

	task automatic restart_lexer();
		lex_state   = M_IDLE;
		prefix_kind = '0;
		pos_line    = 1;
		pos_col     = '0;
		tok_line    = 1;
		tok_col     = '0;
		num_val     = '0;
		kw_buf      = '0;
		kw_len      = '0;
		text_failed = 1'b0;
	endtask

	task automatic add_word_byte(input logic [7:0] c);
		if (kw_len < 3'd4)
			kw_buf[8*kw_len +: 8] = c;
		if (kw_len < 3'd5)
			kw_len = kw_len + 1'b1;
	endtask

	// predicts the results of one accepted byte and queues them
	task automatic lex_byte(input logic [7:0] c);
		result_t     outs [$];
		result_t     r;
		logic        rescan;
		logic        single;
		logic [4:0]  op;
		logic [4:0]  wk;
		logic [63:0] acc;
		rescan = 1'b0;
		single = 1'b1;
		op = K_SEP;
		pos_col = pos_col + 1'b1;
		case (lex_state)
			M_SKIP: begin
				if (c == CH_EOT) begin
					outs.push_back(token_event(EV_END_FAIL, K_EOF, 0, 0, 0, pos_line, pos_col));
					restart_lexer();
				end
			end
			M_QUOTE: begin
				if (c == CH_QUOTE) begin
					outs.push_back(token_event(EV_DONE, K_QUOTE, 0, 0, 0, tok_line, tok_col));
					lex_state = M_IDLE;
				end else if (c == CH_EOT) begin
					outs.push_back(token_event(EV_ERR, '0, 0, 0, ERR_OPEN_QUOTE, pos_line,
						pos_col));
					outs.push_back(token_event(EV_END_FAIL, K_EOF, 0, 0, 0, pos_line, pos_col));
					restart_lexer();
				end else begin
					outs.push_back(token_event(EV_TEXT, K_QUOTE, c, 0, 0, tok_line, tok_col));
				end
			end
			M_NUM: begin
				if (dec_digit(c)) begin
					acc = {33'd0, num_val} * 64'd10 + 64'(c - "0");
					num_val = (acc > 64'(NUM_MAX)) ? NUM_MAX : acc[NUM_W-1:0];
				end else begin
					outs.push_back(token_event(EV_DONE, K_NUM, 0, num_val, 0, tok_line, tok_col));
					lex_state = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_ZERO: begin
				if (dec_digit(c)) begin
					outs.push_back(token_event(EV_ERR, '0, 0, 0, ERR_LEAD_ZERO, pos_line,
						pos_col));
					text_failed = 1'b1;
					lex_state = M_SKIP;
				end else begin
					outs.push_back(token_event(EV_DONE, K_NUM, 0, 0, 0, tok_line, tok_col));
					lex_state = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_WORD: begin
				if (c != CH_SP && c != ";" && c != CH_NL && c != CH_EOT) begin
					add_word_byte(c);
					outs.push_back(token_event(EV_TEXT, K_WORD, c, 0, 0, tok_line, tok_col));
				end else begin
					case ({kw_len, kw_buf})
						{3'd2, KW_TO}:   wk = K_TO;
						{3'd2, KW_IF}:   wk = K_IF;
						{3'd4, KW_ELIF}: wk = K_ELIF;
						{3'd4, KW_ELSE}: wk = K_ELSE;
						{3'd4, KW_THEN}: wk = K_THEN;
						{3'd3, KW_END}:  wk = K_END;
						default:         wk = K_WORD;
					endcase
					outs.push_back(token_event(EV_DONE, wk, 0, 0, 0, tok_line, tok_col));
					lex_state = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_NAME: begin
				if (name_tail(c)) begin
					outs.push_back(token_event(EV_TEXT, K_MARK + prefix_kind, c, 0, 0, tok_line,
						tok_col));
				end else begin
					outs.push_back(token_event(EV_DONE, K_MARK + prefix_kind, 0, 0, 0, tok_line,
						tok_col));
					lex_state = M_IDLE;
					rescan = 1'b1;
				end
			end
			default: begin
				lex_state = M_IDLE;
				rescan = 1'b1;
			end
		endcase
		// terminating byte handled again as a fresh byte
		if (rescan) begin
			case (c)
				";":     op = K_SEP;
				"+":     op = K_ADD;
				"-":     op = K_SUB;
				"=":     op = K_EQ;
				"!":     op = K_NOT;
				">":     op = K_RIGHT;
				"<":     op = K_LEFT;
				"(":     op = K_LPAR;
				")":     op = K_RPAR;
				default: single = 1'b0;
			endcase
			if (single) begin
				outs.push_back(token_event(EV_DONE, op, 0, 0, 0, pos_line, pos_col));
			end else if (c == CH_SP || c == CH_NL) begin
			end else if (c == CH_EOT) begin
				outs.push_back(token_event(text_failed ? EV_END_FAIL : EV_END_OK, K_EOF, 0, 0, 0,
					pos_line, pos_col));
				restart_lexer();
			end else begin
				tok_line = pos_line;
				tok_col  = pos_col;
				if (c == ":" || c == "@" || c == "$") begin
					prefix_kind = (c == ":") ? 2'd0 : (c == "@") ? 2'd1 : 2'd2;
					lex_state = M_NAME;
					outs.push_back(token_event(EV_TEXT, K_MARK + prefix_kind, c, 0, 0, tok_line,
						tok_col));
				end else if (c == "0") begin
					lex_state = M_ZERO;
				end else if (dec_digit(c)) begin
					num_val = NUM_W'(c - "0");
					lex_state = M_NUM;
				end else if (c == CH_QUOTE) begin
					lex_state = M_QUOTE;
					outs.push_back(token_event(EV_TEXT, K_QUOTE, c, 0, 0, tok_line, tok_col));
				end else begin
					kw_buf = '0;
					kw_len = '0;
					add_word_byte(c);
					lex_state = M_WORD;
					outs.push_back(token_event(EV_TEXT, K_WORD, c, 0, 0, tok_line, tok_col));
				end
			end
		end
		if (c == CH_NL) begin
			pos_line = pos_line + 1'b1;
			pos_col  = '0;
		end
		foreach (outs[i]) begin
			r = outs[i];
			r.last = (i == outs.size() - 1);
			token_events_due.push_back(r);
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		src_bytes.push_back(b);
		bytes_built++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_name_byte();
		logic [7:0] b;
		case ($urandom_range(5))
			0:       b = 8'($urandom_range("a", "z"));
			1:       b = 8'($urandom_range("A", "Z"));
			2:       b = 8'($urandom_range("0", "9"));
			3:       b = "_";
			4:       b = $urandom_range(1) ? 8'hA8 : 8'hB8;
			default: b = 8'($urandom_range(8'hC0, 8'hFF));
		endcase
		return b;
	endfunction

	function automatic logic [7:0] rand_word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == CH_SP || b == ";" || b == CH_NL);
		return b;
	endfunction

	task automatic push_keyword();
		logic [31:0] w;
		int          n;
		case ($urandom_range(5))
			0:       begin w = KW_TO;   n = 2; end
			1:       begin w = KW_IF;   n = 2; end
			2:       begin w = KW_ELIF; n = 4; end
			3:       begin w = KW_ELSE; n = 4; end
			4:       begin w = KW_THEN; n = 4; end
			default: begin w = KW_END;  n = 3; end
		endcase
		// sometimes cut short or run on, so near misses show up as plain words
		if ($urandom_range(7) == 0)
			n = n - 1;
		for (int i = 0; i < n; i++)
			push_byte(w[8*i +: 8]);
		if ($urandom_range(4) == 0)
			push_byte(rand_name_byte());
	endtask

	task automatic add_random_text();
		int tokens;
		int sel;
		int n;
		int t;
		logic [7:0] b;
		tokens = $urandom_range(1, 12);
		for (t = 0; t < tokens; t++) begin
			sel = $urandom_range(99);
			if (sel < 15) begin
				push_byte(single_ops[$urandom_range(8)]);
			end else if (sel < 27) begin
				push_byte(name_marks[$urandom_range(2)]);
				n = $urandom_range(0, 5);
				repeat (n) push_byte(rand_name_byte());
			end else if (sel < 42) begin
				push_byte(8'($urandom_range("1", "9")));
				n = ($urandom_range(9) < 7) ? $urandom_range(0, 3) : $urandom_range(8, 14);
				repeat (n) push_byte(8'($urandom_range("0", "9")));
			end else if (sel < 52) begin
				push_byte(CH_QUOTE);
				n = $urandom_range(0, 6);
				repeat (n) begin
					do
						b = 8'($urandom_range(1, 255));
					while (b == CH_QUOTE);
					push_byte(($urandom_range(4) == 0) ? CH_NL : b);
				end
				push_byte(CH_QUOTE);
			end else if (sel < 67) begin
				push_keyword();
			end else if (sel < 82) begin
				case ($urandom_range(3))
					0, 1:    push_byte(8'($urandom_range("a", "z")));
					2:       push_byte(8'($urandom_range(8'h80, 8'hFF)));
					default: push_byte($urandom_range(1) ? 8'h09 : 8'h0D);
				endcase
				n = $urandom_range(0, 6);
				repeat (n) push_byte(rand_word_byte());
			end else if (sel < 90) begin
				n = $urandom_range(1, 4);
				repeat (n) push_byte(8'($urandom_range(1, 255)));
			end else if (sel < 94) begin
				push_byte("0");
				push_byte(8'($urandom_range("0", "9")));
			end else if (sel < 97) begin
				push_byte("0");
			end else begin
				// quote left open up to the end of text
				push_byte(CH_QUOTE);
				n = $urandom_range(0, 3);
				repeat (n) push_byte(8'($urandom_range("a", "z")));
				break;
			end
			case ($urandom_range(3))
				0:       ;
				2:       push_byte(CH_NL);
				default: push_byte(CH_SP);
			endcase
		end
		push_byte(CH_EOT);
		texts_built++;
	endtask

	task automatic add_random_bytes(input int n);
		int start;
		start = bytes_built;
		while (bytes_built - start < n)
			add_random_text();
	endtask

	task automatic wait_for_drain();
		while (src_bytes.size() != 0 || ch_valid || token_events_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			failures++;
		end
	endtask

	// sender: a new byte only once the previous transfer is done
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_valid <= 1'b0;
			ch       <= '0;
		end else begin
			if (ch_valid && ch_ready) begin
				lex_byte(ch);
				bytes_sent++;
			end
			if (!ch_valid || ch_ready) begin
				if (src_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
					ch_valid <= 1'b1;
					ch       <= src_bytes.pop_front();
				end else begin
					ch_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ready <= 1'b0;
		else
			res_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (token_events_due.size() == 0) begin
				$display("%0t: unexpected result, event_res %0d kind %0d", $time, event_res,
					kind);
				failures++;
			end else begin
				want = token_events_due.pop_front();
				check_field("event_res", want.event_res, event_res);
				check_field("kind", want.kind, kind);
				check_field("text_byte", want.text_byte, text_byte);
				check_field("number_value", want.number_value, number_value);
				check_field("error_code", want.error_code, error_code);
				check_field("line", want.line, line);
				check_field("column", want.column, column);
				check_field("last", want.last, last);
			end
		end
	end

	initial begin
		restart_lexer();
		send_idle = 21;
		recv_idle = 79;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// single-byte tokens, name with cyrillic letter, quote over a newline
		push_str("=!<>()+-;@");
		push_byte(8'hE9);
		push_str(" '\n'");
		push_byte(CH_EOT);
		// digit after a leading zero, then end inside a quote
		push_str("07");
		push_byte(CH_EOT);
		push_str("'a");
		push_byte(CH_EOT);
		texts_built += 3;
		add_random_bytes(260);
		wait_for_drain();

		send_idle = 79;
		recv_idle = 21;
		add_random_bytes(280);
		wait_for_drain();

		send_idle = 0;
		recv_idle = 0;
		add_random_bytes(290);
		wait_for_drain();

		repeat (10) @(posedge clk);
		$display("covered %0d texts, %0d bytes transferred, %0d results compared",
			texts_built, bytes_sent, results_seen);
		$display("incl. leading zero, open quote, keywords and number saturation");
		if (failures == 0)
			$display("script_char_tokenizer_core regression: pass");
		else
			$display("script_char_tokenizer_core regression: fail");
		$finish;
	end

	initial begin
		#1000000;
		$display("script_char_tokenizer_core regression: fail");
		$finish;
	end

endmodule
